// ----- sv/plcs_pkg.sv -----
// Shared types and constants of the position loop speed command block.
// Used by the register bank, controller, datapath and top level.
// No dependencies.
package plcs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_SCALE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_POSITION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POSITION_GAIN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADZONE_ENTER = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADZONE_EXIT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HW_SPEED_MAX   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_LIMIT     = 3'd6;

    // Register reset values
    localparam logic [31:0] TURN_SCALE_RST     = 32'd1048576;
    localparam logic [31:0] START_POSITION_RST = 32'd0;
    localparam logic [15:0] POSITION_GAIN_RST  = 16'd2099;
    localparam logic [30:0] DEADZONE_ENTER_RST = 31'd26214;
    localparam logic [30:0] DEADZONE_EXIT_RST  = 31'd52429;
    localparam logic [30:0] HW_SPEED_MAX_RST   = 31'd13107200;
    localparam logic [30:0] STEP_LIMIT_RST     = 31'd786432;

    // Gain is Q8.8
    localparam int GAIN_FRAC_BITS = 8;

    typedef struct packed {
        logic        [31:0] turn_scale;
        logic signed [31:0] start_position;
        logic        [15:0] position_gain;
        logic        [30:0] deadzone_enter;
        logic        [30:0] deadzone_exit;
        logic        [30:0] hw_speed_max;
        logic        [30:0] step_limit;
    } cfg_t;

    // Operand selection of the shared multiplier
    typedef enum logic {
        MUL_SCALE,
        MUL_GAIN
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;   // capture an accepted item
        logic     mul_en;    // register a product
        mul_sel_t mul_sel;
        logic     meas_en;   // scale and offset the position
        logic     err_en;    // take the error, update hysteresis
        logic     limit_en;  // gain product, saturate, clamp
        logic     slew_en;   // slew step and output load
    } cmd_t;

endpackage

// ----- sv/plcs_cfg_regs.sv -----
// Configuration register bank of the position loop speed command block.
// Depends on plcs_pkg.
module plcs_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [plcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [plcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output plcs_pkg::cfg_t                     cfg
);
    import plcs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.turn_scale     <= TURN_SCALE_RST;
            cfg_reg.start_position <= START_POSITION_RST;
            cfg_reg.position_gain  <= POSITION_GAIN_RST;
            cfg_reg.deadzone_enter <= DEADZONE_ENTER_RST;
            cfg_reg.deadzone_exit  <= DEADZONE_EXIT_RST;
            cfg_reg.hw_speed_max   <= HW_SPEED_MAX_RST;
            cfg_reg.step_limit     <= STEP_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TURN_SCALE:     cfg_reg.turn_scale     <= cfg_wdata;
                REG_START_POSITION: cfg_reg.start_position <= cfg_wdata;
                REG_POSITION_GAIN:  cfg_reg.position_gain  <= cfg_wdata[15:0];
                REG_DEADZONE_ENTER: cfg_reg.deadzone_enter <= cfg_wdata[30:0];
                REG_DEADZONE_EXIT:  cfg_reg.deadzone_exit  <= cfg_wdata[30:0];
                REG_HW_SPEED_MAX:   cfg_reg.hw_speed_max   <= cfg_wdata[30:0];
                REG_STEP_LIMIT:     cfg_reg.step_limit     <= cfg_wdata[30:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/plcs_ctrl.sv -----
// Sequencing controller of the position loop speed command block.
// Steps the datapath through one item and owns the handshakes. Depends on plcs_pkg.
module plcs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output plcs_pkg::cmd_t  cmd
);
    import plcs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_POS,
        ST_MEAS,
        ST_ERR,
        ST_MUL_GAIN,
        ST_LIMIT,
        ST_SLEW
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    // hold the finished item until the output slot is free
    assign out_load = (state_reg == ST_SLEW) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_MUL_POS;
            ST_MUL_POS:  state_next = ST_MEAS;
            ST_MEAS:     state_next = ST_ERR;
            ST_ERR:      state_next = ST_MUL_GAIN;
            ST_MUL_GAIN: state_next = ST_LIMIT;
            ST_LIMIT:    state_next = ST_SLEW;
            ST_SLEW:     if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.load_in  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mul_en   = (state_reg == ST_MUL_POS) || (state_reg == ST_MUL_GAIN);
        cmd.mul_sel  = (state_reg == ST_MUL_GAIN) ? MUL_GAIN : MUL_SCALE;
        cmd.meas_en  = (state_reg == ST_MEAS);
        cmd.err_en   = (state_reg == ST_ERR);
        cmd.limit_en = (state_reg == ST_LIMIT);
        cmd.slew_en  = out_load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL_POS))
        else $error("accepted item did not start the sequence");

    a_valid_from_slew: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_SLEW))
        else $error("result presented without a slew step");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLEW && out_valid_reg && !m_tready) |=> (state_reg == ST_SLEW))
        else $error("finished item overran a waiting result");

endmodule

// ----- sv/plcs_dp.sv -----
// Datapath of the position loop speed command block: input registers, shared
// multiplier, scaling, hysteresis, clamp and slew stages. Depends on plcs_pkg.
module plcs_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  plcs_pkg::cmd_t      cmd,
    input  plcs_pkg::cfg_t      cfg,
    input  logic signed [31:0]  encoder_count,
    input  logic signed [31:0]  position_ref,
    input  logic signed [31:0]  user_speed_limit,
    output logic signed [31:0]  speed_ref,
    output logic signed [31:0]  measured_position,
    output logic                drive_active
);
    import plcs_pkg::*;

    localparam int POS_SHIFT = 32 - FRAC_BITS;
    localparam logic signed [66:0] MAX67 = 67'sd2147483647;
    localparam logic signed [66:0] MIN67 = -67'sd2147483648;
    localparam logic signed [57:0] MAX58 = 58'sd2147483647;
    localparam logic signed [57:0] MIN58 = -58'sd2147483648;

    logic signed [31:0] count_reg, pref_reg, ulim_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] meas_reg;
    logic signed [32:0] err_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] prev_reg, prev_next;
    logic               drive_reg, drive_next;
    logic signed [31:0] out_meas_reg;
    logic               out_drive_reg;

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;

    logic signed [65:0] scaled;
    logic signed [66:0] pos_sum;
    logic signed [31:0] meas_next;

    logic signed [32:0] err_next;
    logic signed [33:0] err34, enter34, exit34;

    logic signed [65:0] gshift;
    logic signed [31:0] v_sat;
    logic signed [32:0] v33, ul33, umag33, hw33, vmax33, vclamp33;

    logic signed [32:0] dv, step33, prev33;

    always_comb begin
        if (cmd.mul_sel == MUL_SCALE) begin
            mul_a = {count_reg[31], count_reg};
            mul_b = {1'b0, cfg.turn_scale};
        end else begin
            mul_a = err_reg;
            mul_b = {17'd0, cfg.position_gain};
        end
    end

    // position: floor shift of count * scale, plus offset, saturated
    always_comb begin
        scaled  = prod_reg >>> POS_SHIFT;
        pos_sum = {scaled[65], scaled} + 67'($signed(cfg.start_position));
        if (pos_sum > MAX67) begin
            meas_next = 32'sh7FFF_FFFF;
        end else if (pos_sum < MIN67) begin
            meas_next = 32'sh8000_0000;
        end else begin
            meas_next = pos_sum[31:0];
        end
    end

    // error and hysteresis
    always_comb begin
        err_next = {pref_reg[31], pref_reg} - {meas_reg[31], meas_reg};
        err34    = {err_next[32], err_next};
        enter34  = {3'd0, cfg.deadzone_enter};
        exit34   = {3'd0, cfg.deadzone_exit};
        drive_next = drive_reg;
        if (drive_reg) begin
            if (err34 < enter34 && err34 > -enter34) drive_next = 1'b0;
        end else begin
            if (err34 > exit34 || err34 < -exit34) drive_next = 1'b1;
        end
    end

    // gain product, saturation and clamp to the speed limit
    always_comb begin
        gshift = prod_reg >>> GAIN_FRAC_BITS;
        if ($signed(gshift[57:0]) > MAX58) begin
            v_sat = 32'sh7FFF_FFFF;
        end else if ($signed(gshift[57:0]) < MIN58) begin
            v_sat = 32'sh8000_0000;
        end else begin
            v_sat = gshift[31:0];
        end
        v33    = drive_reg ? {v_sat[31], v_sat} : 33'sd0;
        ul33   = {ulim_reg[31], ulim_reg};
        umag33 = ul33[32] ? -ul33 : ul33;
        hw33   = {2'd0, cfg.hw_speed_max};
        vmax33 = (umag33 < hw33) ? umag33 : hw33;
        if (v33 > vmax33) begin
            vclamp33 = vmax33;
        end else if (v33 < -vmax33) begin
            vclamp33 = -vmax33;
        end else begin
            vclamp33 = v33;
        end
    end

    // slew step against the previous command
    always_comb begin
        prev33 = {prev_reg[31], prev_reg};
        step33 = {2'd0, cfg.step_limit};
        dv     = {v_reg[31], v_reg} - prev33;
        if (dv > step33) begin
            dv = step33;
        end else if (dv < -step33) begin
            dv = -step33;
        end
        prev_next = 32'(prev33 + dv);
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            count_reg <= encoder_count;
            pref_reg  <= position_ref;
            ulim_reg  <= user_speed_limit;
        end
        if (cmd.mul_en)   prod_reg <= mul_a * mul_b;
        if (cmd.meas_en)  meas_reg <= meas_next;
        if (cmd.err_en)   err_reg  <= err_next;
        if (cmd.limit_en) v_reg    <= vclamp33[31:0];
        if (cmd.slew_en) begin
            out_meas_reg  <= meas_reg;
            out_drive_reg <= drive_reg;
        end
    end

    // loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg <= 1'b0;
            prev_reg  <= '0;
        end else begin
            if (cmd.err_en)  drive_reg <= drive_next;
            if (cmd.slew_en) prev_reg  <= prev_next;
        end
    end

    assign speed_ref         = prev_reg;
    assign measured_position = out_meas_reg;
    assign drive_active      = out_drive_reg;

    a_slew_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.slew_en |=>
            (($signed({prev_reg[31], prev_reg})
              - $signed({$past(prev_reg[31]), $past(prev_reg)}))
                 <= $signed({2'd0, $past(cfg.step_limit)}))
         && (($signed({prev_reg[31], prev_reg})
              - $signed({$past(prev_reg[31]), $past(prev_reg)}))
                 >= -$signed({2'd0, $past(cfg.step_limit)})))
        else $error("speed command moved by more than the step limit");

    a_drive_only_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.err_en |=> $stable(drive_reg))
        else $error("drive state changed outside the error step");

endmodule

// ----- sv/position_loop_speed_command_top.sv -----
// Top level of the single-axis position loop speed command block.
// Instantiates plcs_cfg_regs, plcs_ctrl and plcs_dp; depends on plcs_pkg.
//
//  Port group  Dir  Data                                   Handshake
//  s_          in   count, position ref, user speed limit  s_tvalid / s_tready
//  m_          out  speed ref, measured position, drive    m_tvalid / m_tready
//  cfg_        in   register index and write data          cfg_wr_en, no wait
//
// A result is presented once the sequencer has run six steps after the capture,
// MUL_POS, MEAS, ERR, MUL_GAIN, LIMIT and SLEW, two of which use the one shared
// 33x33 multiplier. No new item is taken while one is still in the sequence.
// The next item is accepted once the previous one has been moved to the output
// register, so a waiting result only stalls the final step.
// Reset (aresetn, synchronous, active low) clears the sequencer, the drive
// state, the previous command and restores the register defaults.
module position_loop_speed_command_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] encoder_count, [63:32] position_ref, [95:64] user_speed_limit
    input  logic [95:0]                         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] speed_ref, [63:32] measured_position, [64] drive_active, [71:65] zero
    output logic [71:0]                         m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [plcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [plcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import plcs_pkg::*;

    cfg_t               cfg;
    cmd_t               cmd;
    logic signed [31:0] speed_ref;
    logic signed [31:0] measured_position;
    logic               drive_active;

    plcs_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    plcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    plcs_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg               (cfg),
        .encoder_count     (s_tdata[31:0]),
        .position_ref      (s_tdata[63:32]),
        .user_speed_limit  (s_tdata[95:64]),
        .speed_ref         (speed_ref),
        .measured_position (measured_position),
        .drive_active      (drive_active)
    );

    assign m_tdata = {7'd0, drive_active, measured_position, speed_ref};

endmodule
